/* rtl/tcds_pkg.sv */
// Shared types and constants for the texture cube dimension sizer.
// No dependencies; imported by every module of the block.
package tcds_pkg;

    localparam int COUNT_BITS = 32;                    // significant bits of a count
    localparam int NUM_CELLS  = (COUNT_BITS + 2) / 3;  // one root bit per cell
    localparam int PAD_W      = 3 * NUM_CELLS;         // radicand padded to whole digits
    localparam int ROOT_W     = NUM_CELLS;
    localparam int ROOT_SQ_W  = 2 * ROOT_W;
    localparam int REM_W      = 2 * ROOT_W + 5;
    localparam int DIM_W      = 12;
    localparam int PAIR_W     = 2 * DIM_W;
    localparam int PROD_W     = 3 * DIM_W;
    localparam int MODE_W     = 2;

    localparam int MODE_UNIFORM_BIT = 0;
    localparam int MODE_POW2_BIT    = 1;

    // Word handed from cell to cell of the cube root chain.
    typedef struct packed {
        logic [COUNT_BITS-1:0] count;    // count with zero replaced by one
        logic [PAD_W-1:0]      rad;      // digits not yet consumed, top aligned
        logic [REM_W-1:0]      rem;      // radicand prefix minus root cubed
        logic [ROOT_W-1:0]     root;
        logic [ROOT_SQ_W-1:0]  root_sq;
    } root_word_t;

    // Result fields, dim_x in the low bits.
    typedef struct packed {
        logic [DIM_W-1:0] dim_z;
        logic [DIM_W-1:0] dim_y;
        logic [DIM_W-1:0] dim_x;
    } dims_t;

    // Smallest power of two at or above d, for 1 <= d <= 2048.
    function automatic logic [DIM_W-1:0] next_pow2(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] p;
        p = DIM_W'(1);
        for (int i = 0; i < DIM_W - 1; i++)
        begin
            if ((DIM_W'(1) << i) < d)
            begin
                p = DIM_W'(1) << (i + 1);
            end
        end
        return p;
    endfunction

endpackage

/* rtl/tcds_cell.sv */
// One cell of the cube root chain: settles one root bit per word.
// Depends on tcds_pkg.
module tcds_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tcds_pkg::root_word_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tcds_pkg::root_word_t out_data
);
    import tcds_pkg::*;

    logic       valid_reg;
    root_word_t data_reg;
    root_word_t data_next;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;

    // Bring down three digits; trial = 12 r^2 + 6 r + 1 = (2r+1)^3 - 8 r^3.
    always_comb
    begin
        rem_sh = {in_data.rem[REM_W-4:0], in_data.rad[PAD_W-1 -: 3]};
        trial  = (REM_W'(in_data.root_sq) << 3) + (REM_W'(in_data.root_sq) << 2)
               + (REM_W'(in_data.root) << 2) + (REM_W'(in_data.root) << 1)
               + REM_W'(1);
        data_next       = in_data;
        data_next.rad   = in_data.rad << 3;
        if (rem_sh >= trial)
        begin
            data_next.rem     = rem_sh - trial;
            data_next.root    = {in_data.root[ROOT_W-2:0], 1'b1};
            data_next.root_sq = (in_data.root_sq << 2)
                              + (ROOT_SQ_W'(in_data.root) << 2) + ROOT_SQ_W'(1);
        end
        else
        begin
            data_next.rem     = rem_sh;
            data_next.root    = {in_data.root[ROOT_W-2:0], 1'b0};
            data_next.root_sq = in_data.root_sq << 2;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

`ifndef ASSERT_OFF
    a_root_sq: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ((ROOT_SQ_W'(data_reg.root) * ROOT_SQ_W'(data_reg.root))
                       == data_reg.root_sq))
        else $error("root_sq out of step with root");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.rem <= (REM_W'(data_reg.root_sq) * 3
                                        + REM_W'(data_reg.root) * 3)))
        else $error("remainder exceeds next root step");
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg |-> in_ready)
        else $error("empty cell not ready");
`endif

endmodule

/* rtl/tcds_shape.sv */
// Turns the floor cube root into the three texture dimensions.
// Four stages: base/small select, two multiplies, compare and pick. Depends on tcds_pkg.
module tcds_shape (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tcds_pkg::MODE_W-1:0]   size_mode,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  tcds_pkg::root_word_t          in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output tcds_pkg::dims_t               out_dims
);
    import tcds_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    logic [DIM_W-1:0]      base1_reg, small1_reg;
    logic [COUNT_BITS-1:0] cnt1_reg;
    logic [DIM_W-1:0]      base2_reg, small2_reg;
    logic [COUNT_BITS-1:0] cnt2_reg;
    logic [PAIR_W-1:0]     bs2_reg;
    logic [DIM_W-1:0]      base3_reg, small3_reg;
    logic [COUNT_BITS-1:0] cnt3_reg;
    logic [PROD_W-1:0]     bss3_reg, bbs3_reg;
    dims_t                 dims_reg;

    logic [DIM_W-1:0] ceil_root;
    logic [DIM_W-1:0] base_next;
    logic [DIM_W-1:0] small_next;
    dims_t            dims_next;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // ceil cbrt(c) = floor cbrt(c - 1) + 1
    always_comb
    begin
        ceil_root = DIM_W'(in_data.root) + DIM_W'(1);
        if (size_mode[MODE_POW2_BIT])
        begin
            base_next  = next_pow2(ceil_root);
            small_next = base_next >> 1;
        end
        else
        begin
            base_next  = ceil_root;
            small_next = ceil_root - DIM_W'(1);
        end
    end

    always_comb
    begin
        dims_next.dim_x = base3_reg;
        if (size_mode[MODE_UNIFORM_BIT])
        begin
            dims_next.dim_y = base3_reg;
            dims_next.dim_z = base3_reg;
        end
        else if (bss3_reg >= PROD_W'(cnt3_reg))
        begin
            dims_next.dim_y = small3_reg;
            dims_next.dim_z = small3_reg;
        end
        else if (bbs3_reg >= PROD_W'(cnt3_reg))
        begin
            dims_next.dim_y = base3_reg;
            dims_next.dim_z = small3_reg;
        end
        else
        begin
            dims_next.dim_y = base3_reg;
            dims_next.dim_z = base3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            base1_reg  <= base_next;
            small1_reg <= small_next;
            cnt1_reg   <= in_data.count;
        end
        if (rdy2 && v1_reg)
        begin
            base2_reg  <= base1_reg;
            small2_reg <= small1_reg;
            cnt2_reg   <= cnt1_reg;
            bs2_reg    <= PAIR_W'(base1_reg) * PAIR_W'(small1_reg);
        end
        if (rdy3 && v2_reg)
        begin
            base3_reg  <= base2_reg;
            small3_reg <= small2_reg;
            cnt3_reg   <= cnt2_reg;
            bss3_reg   <= PROD_W'(bs2_reg) * PROD_W'(small2_reg);
            bbs3_reg   <= PROD_W'(bs2_reg) * PROD_W'(base2_reg);
        end
        if (rdy4 && v3_reg)
        begin
            dims_reg <= dims_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_dims  = dims_reg;

`ifndef ASSERT_OFF
    a_dim_order: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> (dims_reg.dim_x >= dims_reg.dim_y && dims_reg.dim_y >= dims_reg.dim_z))
        else $error("dimensions out of order");
    a_dim_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> (dims_reg.dim_z != '0))
        else $error("zero dimension");
    a_small_step: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> (small1_reg < base1_reg))
        else $error("small dimension not below base");
`endif

endmodule

/* rtl/texture_cube_dimension_sizer.sv */
// Top level of the texture cube dimension sizer: mode register, cube root chain, shape stages.
// Depends on tcds_pkg, tcds_cell, tcds_shape.
//
//  channel   dir   word                                  accepted when
//  s_*       in    element_count [31:0]                  s_tvalid && s_tready
//  m_*       out   dim_x [11:0] dim_y [23:12] dim_z [35:24]  m_tvalid && m_tready
//  cfg_*     in    size_mode [1:0]                       cfg_wr_en
//
// The chain has 11 cells, one per root bit, followed by four shape stages
// (base select, base*small, two products, compare), the last being the output register.
// A new word is taken every cycle unless an output stall has filled every stage. Every stage
// has its own valid bit and moves when the stage after it is empty or moving, so bubbles fill
// while the output stalls. Reset clears the mode to non-uniform and empties every stage.
module texture_cube_dimension_sizer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [tcds_pkg::MODE_W-1:0]   cfg_wr_data,   // size_mode
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,       // element_count
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [39:0]                   m_tdata        // dim_x, dim_y, dim_z, zero pad
);
    import tcds_pkg::*;

    logic [MODE_W-1:0]     size_mode_reg;
    logic [COUNT_BITS-1:0] count_in;
    logic [COUNT_BITS-1:0] count_fixed;
    root_word_t            entry_word;

    logic       cell_valid [NUM_CELLS+1];
    logic       cell_ready [NUM_CELLS+1];
    root_word_t cell_word  [NUM_CELLS+1];
    dims_t      dims;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_mode_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            size_mode_reg <= cfg_wr_data;
        end
    end

    // zero counts as one; the chain takes the floor cube root of count - 1
    always_comb
    begin
        count_in    = s_tdata[COUNT_BITS-1:0];
        count_fixed = (count_in == '0) ? COUNT_BITS'(1) : count_in;
        entry_word.count   = count_fixed;
        entry_word.rad     = PAD_W'(count_fixed - COUNT_BITS'(1));
        entry_word.rem     = '0;
        entry_word.root    = '0;
        entry_word.root_sq = '0;
    end

    assign cell_valid[0] = s_tvalid;
    assign cell_word[0]  = entry_word;
    assign s_tready      = cell_ready[0];

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        tcds_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cell_valid[i]),
            .in_ready  (cell_ready[i]),
            .in_data   (cell_word[i]),
            .out_valid (cell_valid[i+1]),
            .out_ready (cell_ready[i+1]),
            .out_data  (cell_word[i+1])
        );
    end

    tcds_shape u_shape (
        .clk       (clk),
        .rst_n     (rst_n),
        .size_mode (size_mode_reg),
        .in_valid  (cell_valid[NUM_CELLS]),
        .in_ready  (cell_ready[NUM_CELLS]),
        .in_data   (cell_word[NUM_CELLS]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_dims  (dims)
    );

    assign m_tdata = {4'b0000, dims};

`ifndef ASSERT_OFF
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with output empty");
    a_uniform: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && size_mode_reg[MODE_UNIFORM_BIT]) |->
            (dims.dim_x == dims.dim_y && dims.dim_y == dims.dim_z))
        else $error("uniform mode gave unequal dimensions");
    a_pow2: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && size_mode_reg[MODE_POW2_BIT]) |-> $onehot(dims.dim_x))
        else $error("power-of-two mode gave a non power of two");
`endif

endmodule

/* bench/texture_cube_dimension_sizer_test.sv */
// Self-checking bench for texture_cube_dimension_sizer: corner counts, then random counts per mode.
// Depends on tcds_pkg and the RTL of the block; checks every output word against its own predictor.
module texture_cube_dimension_sizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tcds_pkg::*;

    typedef enum logic [1:0] {
        MODE_NONUNIFORM      = 2'd0,
        MODE_UNIFORM         = 2'd1,
        MODE_POW2_NONUNIFORM = 2'd2,
        MODE_POW2_UNIFORM    = 2'd3
    } size_mode_e;

    typedef struct {
        logic [31:0] count;
        size_mode_e  mode;
        dims_t       dims;
    } dims_due_t;

    localparam int PIPE_LATENCY  = 16;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_PHASES = 10;
    localparam int RANDOM_ITEMS  = 1750;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [MODE_W-1:0] cfg_wr_data = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [39:0]       m_tdata;

    logic [31:0] counts_to_send [$];
    dims_due_t   dims_due [$];
    size_mode_e  mode_now = MODE_NONUNIFORM;
    bit          word_taken = 1'b0;
    int          burst_left = 1;
    int          gap_left = 0;
    int          stall_left = 0;
    int          stall_style = 0;
    int          cycle_count = 0;
    int          fail_count = 0;
    int          mode_writes = 0;
    int          words_per_mode [4] = '{0, 0, 0, 0};
    int          dims_checked = 0;

    logic [31:0] corner_counts [24] = '{
        32'd0, 32'd1, 32'd2, 32'd7, 32'd8, 32'd9, 32'd63, 32'd64, 32'd65,
        32'd810, 32'd811, 32'd900, 32'd901,
        32'd134217728, 32'd134217729, 32'd1073741824, 32'd1073741825,
        32'd4291015625, 32'd4291015626, 32'hFFFF_FFFF,
        32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'd27
    };

    texture_cube_dimension_sizer u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #6 clk = ~clk;

    // Exact ceiling cube root, then the shape the mode asks for.
    function automatic dims_t cube_dims(input logic [31:0] count, input logic [1:0] mode);
        longint unsigned c, lo, hi, mid, big, little;
        dims_t r;
        c = (count == 32'd0) ? 64'd1 : {32'd0, count};
        lo = 1;
        hi = 2048;
        while (lo < hi)
        begin
            mid = (lo + hi) >> 1;
            if (mid * mid * mid >= c)
                hi = mid;
            else
                lo = mid + 1;
        end
        big = lo;
        if (mode[MODE_POW2_BIT])
        begin
            mid = 1;
            while (mid < big)
                mid = mid << 1;
            big = mid;
            little = big >> 1;
        end
        else
        begin
            little = big - 1;
        end
        r.dim_x = DIM_W'(big);
        if (mode[MODE_UNIFORM_BIT] || (big * big * little < c))
        begin
            r.dim_y = DIM_W'(big);
            r.dim_z = DIM_W'(big);
        end
        else if (big * little * little >= c)
        begin
            r.dim_y = DIM_W'(little);
            r.dim_z = DIM_W'(little);
        end
        else
        begin
            r.dim_y = DIM_W'(big);
            r.dim_z = DIM_W'(little);
        end
        return r;
    endfunction

    // Counts sitting on or next to a shape threshold: d^3, d*s*s, d*d*s with s = d-1 or d/2.
    function automatic logic [31:0] threshold_count();
        longint unsigned d, s, v;
        int offset;
        d = $urandom_range(1, 1626);
        if ($urandom_range(0, 2) == 0)
            d = 64'd1 << $urandom_range(0, 11);
        s = $urandom_range(0, 1) ? d - 1 : d >> 1;
        case ($urandom_range(0, 2))
            0: v = d * d * d;
            1: v = d * s * s;
            default: v = d * d * s;
        endcase
        offset = $urandom_range(0, 2) - 1;
        if (offset < 0 && v == 0)
            v = 0;
        else if (offset < 0)
            v = v - 1;
        else
            v = v + offset;
        if (v > 64'hFFFF_FFFF)
            v = 64'hFFFF_FFFF - $urandom_range(0, 3);
        return v[31:0];
    endfunction

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("texture_cube_dimension_sizer_test failed");
            $finish;
        end
    end

    // Monitor: tracks the mode, records accepted counts, checks output words.
    always @(posedge clk)
    begin
        dims_due_t due;
        dims_t     got;
        word_taken = rst_n && s_tvalid && s_tready;
        if (rst_n && cfg_wr_en)
            mode_now = size_mode_e'(cfg_wr_data);
        if (word_taken)
        begin
            due.count = s_tdata;
            due.mode  = mode_now;
            due.dims  = cube_dims(s_tdata, mode_now);
            dims_due.push_back(due);
            words_per_mode[mode_now]++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got = dims_t'(m_tdata[PROD_W-1:0]);
            if (dims_due.size() == 0)
            begin
                $error("unexpected output word %h", m_tdata);
                fail_count++;
            end
            else
            begin
                due = dims_due.pop_front();
                dims_checked++;
                if (got.dim_x !== due.dims.dim_x)
                begin
                    $error("dim_x (count %0d, mode %s): expected %0d, got %0d",
                           due.count, due.mode.name(), due.dims.dim_x, got.dim_x);
                    fail_count++;
                end
                if (got.dim_y !== due.dims.dim_y)
                begin
                    $error("dim_y (count %0d, mode %s): expected %0d, got %0d",
                           due.count, due.mode.name(), due.dims.dim_y, got.dim_y);
                    fail_count++;
                end
                if (got.dim_z !== due.dims.dim_z)
                begin
                    $error("dim_z (count %0d, mode %s): expected %0d, got %0d",
                           due.count, due.mode.name(), due.dims.dim_z, got.dim_z);
                    fail_count++;
                end
            end
        end
    end

    // Driver: bursts of words with random gaps in between.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (s_tvalid && !word_taken)
        begin
            // hold the word until it is taken
        end
        else if (gap_left > 0)
        begin
            s_tvalid <= 1'b0;
            gap_left--;
        end
        else if (counts_to_send.size() != 0)
        begin
            s_tvalid <= 1'b1;
            s_tdata  <= counts_to_send.pop_front();
            burst_left--;
            if (burst_left <= 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
        end
        else
        begin
            s_tvalid <= 1'b0;
        end
    end

    // Receiver: stall style changes periodically.
    always @(negedge clk)
    begin
        if (cycle_count % 300 == 0)
            stall_style = $urandom_range(0, 2);
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else if (stall_style == 1 && $urandom_range(0, 3) == 0)
        begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end
        else if (stall_style == 2 && $urandom_range(0, 15) == 0)
        begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 19);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    task automatic wait_idle();
        while (counts_to_send.size() != 0 || s_tvalid || dims_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_mode(input size_mode_e mode);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        mode_writes++;
        @(negedge clk);
    endtask

    task automatic queue_random(input int n);
        int pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                counts_to_send.push_back($urandom);
            else if (pick < 8)
                counts_to_send.push_back(threshold_count());
            else if (pick < 9)
                counts_to_send.push_back($urandom_range(0, 4096));
            else
                counts_to_send.push_back($urandom_range(0, 32'd1 << $urandom_range(0, 31)));
        end
    endtask

    initial
    begin
        size_mode_e mode;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // corner counts under every mode, the reset mode first
        for (int m = 0; m < 4; m++)
        begin
            if (m != 0)
                write_mode(size_mode_e'(m));
            foreach (corner_counts[i])
                counts_to_send.push_back(corner_counts[i]);
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == 0)
                mode = MODE_POW2_UNIFORM;
            else if (ph == 1)
                mode = MODE_NONUNIFORM;
            else
                mode = size_mode_e'($urandom_range(0, 3));
            write_mode(mode);
            queue_random(RANDOM_ITEMS / RANDOM_PHASES);
        end

        wait_idle();
        repeat (2 * PIPE_LATENCY) @(negedge clk);
        if (dims_due.size() != 0)
        begin
            $error("%0d expected words never arrived", dims_due.size());
            fail_count++;
        end

        $display("Checked %0d words over %0d mode writes; words per mode (0..3): %0d %0d %0d %0d",
                 dims_checked, mode_writes, words_per_mode[0], words_per_mode[1],
                 words_per_mode[2], words_per_mode[3]);
        $display("Corner counts ran in every mode; random counts mixed full range and thresholds.");
        if (fail_count == 0)
            $display("texture_cube_dimension_sizer_test passed");
        else
            $display("texture_cube_dimension_sizer_test failed");
        $finish;
    end

endmodule

/* files.f */
rtl/tcds_pkg.sv
rtl/tcds_cell.sv
rtl/tcds_shape.sv
rtl/texture_cube_dimension_sizer.sv
bench/texture_cube_dimension_sizer_test.sv
